FILE: sv/lmmc_pkg.sv
`default_nettype none

package lmmc_pkg;

	// Width of the configuration write data (widest register)
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned HOLD_W      = 10;
	localparam int unsigned DUTY_W      = 8;
	localparam int unsigned MODE_W      = 3;

	localparam logic [HOLD_W-1:0] HOLD_MAX = 10'd1023;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BLINK_HALF_A    = 3'd0,
		REG_BLINK_HALF_B    = 3'd1,
		REG_BLINK_HALF_C    = 3'd2,
		REG_TOGGLE_INTERVAL = 3'd3,
		REG_FADE_INTERVAL   = 3'd4,
		REG_FADE_STEP       = 3'd5,
		REG_DEBOUNCE_TICKS  = 3'd6
	} reg_index_t;

	// Register reset values
	localparam logic [15:0]       RST_BLINK_HALF_A    = 16'd50;
	localparam logic [15:0]       RST_BLINK_HALF_B    = 16'd100;
	localparam logic [15:0]       RST_BLINK_HALF_C    = 16'd200;
	localparam logic [15:0]       RST_TOGGLE_INTERVAL = 16'd100;
	localparam logic [15:0]       RST_FADE_INTERVAL   = 16'd50;
	localparam logic [7:0]        RST_FADE_STEP       = 8'd2;
	localparam logic [HOLD_W-1:0] RST_DEBOUNCE_TICKS  = 10'd100;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 3'd0,
		MODE_BLINK_A = 3'd1,
		MODE_BLINK_B = 3'd2,
		MODE_BLINK_C = 3'd3,
		MODE_TOGGLE  = 3'd4,
		MODE_FADE    = 3'd5
	} mode_t;

endpackage

`default_nettype wire

FILE: sv/led_mode_menu_controller_top.sv
`default_nettype none
// LED mode menu controller: one button tick in, one LED/fade result out.
// The result is registered: valid at the output register in the cycle after the input transfer.
// Throughput: one tick per clock while the receiver takes results; the single-pass
// update of the debounce, mode and timer registers is combinational. A result
// held back by the receiver stalls the input until that result is transferred.
// Reset (arst_n low, asynchronous): config and state registers at their defaults, mode off, no result.
module led_mode_menu_controller_top #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write port
	input  wire                                   cfg_wr_en,
	input  wire  [lmmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [lmmc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// tick input
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   button_level,
	// result output
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  led_on,
	output logic [lmmc_pkg::DUTY_W-1:0]           fade_duty,
	output logic [lmmc_pkg::MODE_W-1:0]           current_mode
);

	// Compare width: wide enough for both the timer and a 16-bit interval, so an
	// interval above the timer's saturation value never fires.
	localparam int unsigned CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// ---------------------------------------------------------------- config
	logic [15:0]                         blink_half_a_q;
	logic [15:0]                         blink_half_b_q;
	logic [15:0]                         blink_half_c_q;
	logic [15:0]                         toggle_interval_q;
	logic [15:0]                         fade_interval_q;
	logic [7:0]                          fade_step_q;
	logic [lmmc_pkg::HOLD_W-1:0]         debounce_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_a_q    <= lmmc_pkg::RST_BLINK_HALF_A;
			blink_half_b_q    <= lmmc_pkg::RST_BLINK_HALF_B;
			blink_half_c_q    <= lmmc_pkg::RST_BLINK_HALF_C;
			toggle_interval_q <= lmmc_pkg::RST_TOGGLE_INTERVAL;
			fade_interval_q   <= lmmc_pkg::RST_FADE_INTERVAL;
			fade_step_q       <= lmmc_pkg::RST_FADE_STEP;
			debounce_ticks_q  <= lmmc_pkg::RST_DEBOUNCE_TICKS;
		end else if (cfg_wr_en) begin
			// Drop writes to indexes beyond the register list
			case (lmmc_pkg::reg_index_t'(cfg_index))
				lmmc_pkg::REG_BLINK_HALF_A:    blink_half_a_q    <= cfg_data;
				lmmc_pkg::REG_BLINK_HALF_B:    blink_half_b_q    <= cfg_data;
				lmmc_pkg::REG_BLINK_HALF_C:    blink_half_c_q    <= cfg_data;
				lmmc_pkg::REG_TOGGLE_INTERVAL: toggle_interval_q <= cfg_data;
				lmmc_pkg::REG_FADE_INTERVAL:   fade_interval_q   <= cfg_data;
				lmmc_pkg::REG_FADE_STEP:       fade_step_q       <= cfg_data[7:0];
				lmmc_pkg::REG_DEBOUNCE_TICKS:
					debounce_ticks_q <= cfg_data[lmmc_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- state
	logic                                last_raw_q;
	logic                                stable_level_q;
	logic [lmmc_pkg::HOLD_W-1:0]         hold_count_q;
	lmmc_pkg::mode_t                     mode_q;
	logic [TIMER_WIDTH-1:0]              phase_count_q;
	logic                                led_level_q;
	logic [lmmc_pkg::DUTY_W-1:0]         brightness_q;
	logic                                fade_rising_q;
	logic [TIMER_WIDTH-1:0]              fade_count_q;
	logic [lmmc_pkg::DUTY_W-1:0]         duty_out_q;

	logic                                stable_level_d;
	logic [lmmc_pkg::HOLD_W-1:0]         hold_count_d;
	lmmc_pkg::mode_t                     mode_d;
	logic [TIMER_WIDTH-1:0]              phase_count_d;
	logic                                led_level_d;
	logic [lmmc_pkg::DUTY_W-1:0]         brightness_d;
	logic                                fade_rising_d;
	logic [TIMER_WIDTH-1:0]              fade_count_d;
	logic [lmmc_pkg::DUTY_W-1:0]         duty_out_d;
	logic                                led_out_d;

	logic                                in_xfer;
	logic                                mode_adv;
	logic [TIMER_WIDTH-1:0]              phase_base;
	logic [TIMER_WIDTH-1:0]              fade_base;
	logic [TIMER_WIDTH-1:0]              phase_inc;
	logic [TIMER_WIDTH-1:0]              fade_inc;
	logic [15:0]                         period;
	logic [lmmc_pkg::DUTY_W:0]           bright_sum;

	assign in_ready = !out_valid || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Debounce and mode advance
	always_comb begin
		stable_level_d = stable_level_q;
		hold_count_d   = hold_count_q;
		mode_d         = mode_q;
		mode_adv       = 1'b0;
		if (button_level != last_raw_q) begin
			// any raw change restarts the hold
			hold_count_d = '0;
		end else if (hold_count_q >= debounce_ticks_q) begin
			if (button_level != stable_level_q) begin
				stable_level_d = button_level;
				if (button_level) begin
					mode_adv = 1'b1;
					mode_d   = (mode_q == lmmc_pkg::MODE_FADE) ? lmmc_pkg::MODE_OFF
					         : lmmc_pkg::mode_t'(mode_q + 3'd1);
				end
			end
		end else if (hold_count_q < lmmc_pkg::HOLD_MAX) begin
			hold_count_d = hold_count_q + 1'b1;
		end
	end

	// Mode behavior, seen after a possible mode change
	always_comb begin
		phase_base = mode_adv ? '0 : phase_count_q;
		fade_base  = mode_adv ? '0 : fade_count_q;
		phase_inc  = (phase_base == TIMER_MAX) ? TIMER_MAX : phase_base + 1'b1;
		fade_inc   = (fade_base == TIMER_MAX) ? TIMER_MAX : fade_base + 1'b1;
		bright_sum = {1'b0, brightness_q} + {1'b0, fade_step_q};

		phase_count_d = phase_base;
		fade_count_d  = fade_base;
		led_level_d   = mode_adv ? 1'b0 : led_level_q;
		brightness_d  = brightness_q;
		fade_rising_d = fade_rising_q;
		duty_out_d    = duty_out_q;
		led_out_d     = 1'b0;

		case (mode_d)
			lmmc_pkg::MODE_BLINK_A: period = blink_half_a_q;
			lmmc_pkg::MODE_BLINK_B: period = blink_half_b_q;
			lmmc_pkg::MODE_BLINK_C: period = blink_half_c_q;
			default:                period = toggle_interval_q;
		endcase

		case (mode_d) inside
			[lmmc_pkg::MODE_BLINK_A:lmmc_pkg::MODE_TOGGLE]: begin
				phase_count_d = phase_inc;
				if (CMP_W'(phase_inc) >= CMP_W'(period)) begin
					led_level_d   = !led_level_d;
					phase_count_d = '0;
				end
				led_out_d = led_level_d;
			end
			lmmc_pkg::MODE_FADE: begin
				fade_count_d = fade_inc;
				if (CMP_W'(fade_inc) >= CMP_W'(fade_interval_q)) begin
					fade_count_d = '0;
					duty_out_d   = brightness_q;
					if (fade_rising_q) begin
						// saturate at the top and turn around
						if (bright_sum >= {1'b0, lmmc_pkg::DUTY_MAX}) begin
							brightness_d  = lmmc_pkg::DUTY_MAX;
							fade_rising_d = 1'b0;
						end else begin
							brightness_d = bright_sum[lmmc_pkg::DUTY_W-1:0];
						end
					end else begin
						if (brightness_q <= fade_step_q) begin
							brightness_d  = '0;
							fade_rising_d = 1'b1;
						end else begin
							brightness_d = brightness_q - fade_step_q;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Advance state only on an input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q     <= 1'b1;
			stable_level_q <= 1'b0;
			hold_count_q   <= '0;
			mode_q         <= lmmc_pkg::MODE_OFF;
			phase_count_q  <= '0;
			led_level_q    <= 1'b0;
			brightness_q   <= '0;
			fade_rising_q  <= 1'b1;
			fade_count_q   <= '0;
			duty_out_q     <= '0;
		end else if (in_xfer) begin
			last_raw_q     <= button_level;
			stable_level_q <= stable_level_d;
			hold_count_q   <= hold_count_d;
			mode_q         <= mode_d;
			phase_count_q  <= phase_count_d;
			led_level_q    <= led_level_d;
			brightness_q   <= brightness_d;
			fade_rising_q  <= fade_rising_d;
			fade_count_q   <= fade_count_d;
			duty_out_q     <= duty_out_d;
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_xfer) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Hold the payload until the result transfer; load on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			led_on       <= led_out_d;
			fade_duty    <= duty_out_d;
			current_mode <= mode_d;
		end
	end

endmodule

`default_nettype wire
